>>> sv/nmc_pkg.sv
// Package for the Niell mapping coefficient block: stage enables, coefficient tables
// in units of 2^-32, and the seasonal cosine ROM built at elaboration.
// Depends on nothing; imported by every module of the block.
package nmc_pkg;

	localparam int NUM_COEF = 3;
	localparam int NUM_ROW = 5;

	// Latitude span between table rows, 15 degrees in Q8.16.
	localparam logic [23:0] LAT_SPAN = 24'd983040;

	localparam longint YEAR_QUARTERS = 64'sd1461;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint Q30_ONE = 64'sd1073741824;

	// Load enables of the pipeline stages behind the front stage.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
		logic s8;
	} stage_en_t;

	typedef longint coef_tab_t [NUM_COEF][NUM_ROW];
	typedef logic signed [15:0] cos_tab_t [256];

	// Decimal constant given in units of 1e-12, converted to units of 2^-32.
	function automatic longint q32(longint m);
		return (m * 64'sd1048576 + 64'sd122070312) / 64'sd244140625;
	endfunction

	localparam coef_tab_t HYD_AVG = '{
		'{q32(64'sd1276993400), q32(64'sd1268323000), q32(64'sd1246539700),
			q32(64'sd1219604900), q32(64'sd1204599600)},
		'{q32(64'sd2915369500), q32(64'sd2915229900), q32(64'sd2928844500),
			q32(64'sd2902256500), q32(64'sd2902491200)},
		'{q32(64'sd62610505000), q32(64'sd62837393000), q32(64'sd63721774000),
			q32(64'sd63824265000), q32(64'sd64258455000)}
	};

	localparam coef_tab_t HYD_AMP = '{
		'{64'sd0, q32(64'sd12709626), q32(64'sd26523662), q32(64'sd34000452),
			q32(64'sd41202191)},
		'{64'sd0, q32(64'sd21414979), q32(64'sd30160779), q32(64'sd72562722),
			q32(64'sd117233750)},
		'{64'sd0, q32(64'sd90128400), q32(64'sd43497037), q32(64'sd847953480),
			q32(64'sd1703720600)}
	};

	localparam coef_tab_t WET_ROW = '{
		'{q32(64'sd580218970), q32(64'sd567948470), q32(64'sd581180190),
			q32(64'sd597275420), q32(64'sd616416930)},
		'{q32(64'sd1427526800), q32(64'sd1513862500), q32(64'sd1457275200),
			q32(64'sd1500742800), q32(64'sd1759908200)},
		'{q32(64'sd43472961000), q32(64'sd46729510000), q32(64'sd43908931000),
			q32(64'sd44626982000), q32(64'sd54736038000)}
	};

	// Seasonal cosine cos(2*pi*(day-28)/365.25) in Q1.15, by quadrant and Taylor series.
	function automatic logic signed [15:0] season_cos(longint day);
		longint m;
		longint k;
		longint r;
		longint x;
		longint x2;
		longint v;
		longint acc;
		longint mag;
		logic neg;
		m = 64'sd4 * (day - 64'sd28);
		if (m < 0) begin
			m = m + YEAR_QUARTERS;
		end
		m = m % YEAR_QUARTERS;
		k = (64'sd4 * m) / YEAR_QUARTERS;
		r = 64'sd4 * m - k * YEAR_QUARTERS;
		x = (r * HALF_PI_Q30 + YEAR_QUARTERS / 2) / YEAR_QUARTERS;
		x2 = (x * x) >>> 30;
		acc = Q30_ONE;
		if (k == 0 || k == 2) begin
			acc = Q30_ONE - ((x2 * acc) >>> 30) / 64'sd132;
			acc = Q30_ONE - ((x2 * acc) >>> 30) / 64'sd90;
			acc = Q30_ONE - ((x2 * acc) >>> 30) / 64'sd56;
			acc = Q30_ONE - ((x2 * acc) >>> 30) / 64'sd30;
			acc = Q30_ONE - ((x2 * acc) >>> 30) / 64'sd12;
			acc = Q30_ONE - ((x2 * acc) >>> 30) / 64'sd2;
			v = acc;
		end else begin
			acc = Q30_ONE - ((x2 * acc) >>> 30) / 64'sd156;
			acc = Q30_ONE - ((x2 * acc) >>> 30) / 64'sd110;
			acc = Q30_ONE - ((x2 * acc) >>> 30) / 64'sd72;
			acc = Q30_ONE - ((x2 * acc) >>> 30) / 64'sd42;
			acc = Q30_ONE - ((x2 * acc) >>> 30) / 64'sd20;
			acc = Q30_ONE - ((x2 * acc) >>> 30) / 64'sd6;
			v = (x * acc) >>> 30;
		end
		neg = (k == 1 || k == 2);
		mag = (v + 64'sd16384) >>> 15;
		if (mag > 64'sd32767) begin
			mag = 64'sd32767;
		end
		return neg ? 16'(-mag) : 16'(mag);
	endfunction

	// One half of the day ROM: entries base .. base+255, zero past day 366.
	function automatic cos_tab_t build_cos(longint base);
		cos_tab_t tab;
		for (int i = 0; i < 256; i++) begin
			if (base + longint'(i) <= 64'sd366) begin
				tab[i] = season_cos(base + longint'(i));
			end else begin
				tab[i] = '0;
			end
		end
		return tab;
	endfunction

	localparam cos_tab_t COS_LO = build_cos(64'sd0);
	localparam cos_tab_t COS_HI = build_cos(64'sd256);

endpackage

>>> sv/nmc_front.sv
// Front stage of the Niell mapping coefficient pipeline: day clamp, seasonal cosine ROM,
// hemisphere sign, and latitude row segment with offset. Depends on nmc_pkg.
module nmc_front
	import nmc_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic signed [23:0] latitude,
	input  logic [8:0]         day_of_year,
	output logic signed [15:0] cs_s1,
	output logic [2:0]         lo_s1,
	output logic [2:0]         hi_s1,
	output logic [19:0]        t_s1
);

	logic [8:0]         day_c;
	logic signed [15:0] cs_raw;
	logic               south;
	logic [23:0]        mag;
	logic [2:0]         lo;
	logic [2:0]         hi;
	logic [23:0]        base;

	always_comb begin
		day_c = (day_of_year > 9'd366) ? 9'd366 : day_of_year;
		cs_raw = day_c[8] ? COS_HI[day_c[7:0]] : COS_LO[day_c[7:0]];
		south = latitude[23];
		mag = south ? (~latitude + 24'd1) : latitude;
		// Below 15 degrees and above 75 degrees both rows are the end row and the
		// offset is zero, so the blend returns that row unchanged.
		if (mag <= LAT_SPAN) begin
			lo = 3'd0;
			hi = 3'd0;
			base = mag;
		end else if (mag >= 24'(5 * LAT_SPAN)) begin
			lo = 3'd4;
			hi = 3'd4;
			base = mag;
		end else if (mag <= 24'(2 * LAT_SPAN)) begin
			lo = 3'd0;
			hi = 3'd1;
			base = LAT_SPAN;
		end else if (mag <= 24'(3 * LAT_SPAN)) begin
			lo = 3'd1;
			hi = 3'd2;
			base = 24'(2 * LAT_SPAN);
		end else if (mag <= 24'(4 * LAT_SPAN)) begin
			lo = 3'd2;
			hi = 3'd3;
			base = 24'(3 * LAT_SPAN);
		end else begin
			lo = 3'd3;
			hi = 3'd4;
			base = 24'(4 * LAT_SPAN);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s1 <= south ? -cs_raw : cs_raw;
			lo_s1 <= lo;
			hi_s1 <= hi;
			t_s1 <= 20'(mag - base);
		end
	end

endmodule

>>> sv/nmc_lane.sv
// One coefficient lane: per-row seasonal correction, linear blend over latitude,
// and rounded division by the row span. Depends on nmc_pkg for the stage enables.
module nmc_lane
	import nmc_pkg::*;
(
	input  logic               clk,
	input  stage_en_t          en,
	input  logic signed [15:0] cs_s1,
	input  logic [19:0]        t_s1,
	input  logic [28:0]        avg0,
	input  logic [28:0]        avg1,
	input  logic [23:0]        amp0,
	input  logic [23:0]        amp1,
	output logic [28:0]        coef
);

	// Reciprocal of 15 scaled by 2^35, exact for every quotient input below 2^31.
	localparam logic [31:0] RECIP15 = 32'd2290649225;
	// Bias that keeps the quotient input non-negative; removed again at the end.
	localparam logic signed [51:0] QBIAS = 52'sd1006632960;
	localparam logic signed [31:0] QBIAS_OUT = 32'sd67108864;

	logic signed [40:0] p0_s2, p1_s2;
	logic [28:0]        avg0_s2, avg1_s2;
	logic [19:0]        t_s2, t_s3, t_s4;
	logic signed [30:0] h0_s3, h1_s3;
	logic signed [30:0] d_s4, v0_s4, v0_s5, v0_s6, v0_s7;
	logic signed [51:0] prod_s5;
	logic [30:0]        u_s6;
	logic [62:0]        qm_s7;

	logic signed [40:0] pr0, pr1;
	logic signed [51:0] ps;
	logic signed [51:0] y;
	logic signed [31:0] res;

	always_comb begin
		pr0 = p0_s2 + 41'sd16384;
		pr1 = p1_s2 + 41'sd16384;
		ps = prod_s5 + 52'sd491520;
		y = (ps >>> 16) + QBIAS;
		res = 32'(v0_s7) + $signed({4'b0, qm_s7[62:35]}) - QBIAS_OUT;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			p0_s2 <= 41'($signed({1'b0, amp0}) * cs_s1);
			p1_s2 <= 41'($signed({1'b0, amp1}) * cs_s1);
			avg0_s2 <= avg0;
			avg1_s2 <= avg1;
			t_s2 <= t_s1;
		end
		if (en.s3) begin
			h0_s3 <= $signed({2'b0, avg0_s2}) + 31'(pr0 >>> 15);
			h1_s3 <= $signed({2'b0, avg1_s2}) + 31'(pr1 >>> 15);
			t_s3 <= t_s2;
		end
		if (en.s4) begin
			d_s4 <= h1_s3 - h0_s3;
			v0_s4 <= h0_s3;
			t_s4 <= t_s3;
		end
		if (en.s5) begin
			prod_s5 <= 52'(d_s4 * $signed({1'b0, t_s4}));
			v0_s5 <= v0_s4;
		end
		if (en.s6) begin
			u_s6 <= 31'(y);
			v0_s6 <= v0_s5;
		end
		if (en.s7) begin
			qm_s7 <= 63'(u_s6 * RECIP15);
			v0_s7 <= v0_s6;
		end
		if (en.s8) begin
			coef <= res[28:0];
		end
	end

endmodule

>>> sv/niell_mapping_coefficients.sv
// Top level of the Niell mapping coefficient block: valid bits, stall control and
// six coefficient lanes. Depends on nmc_pkg, nmc_front and nmc_lane.
//
// Usage: an input beat carries latitude (signed Q8.16 degrees, north positive) and
// day_of_year (1 is January first; values above 366 count as 366). Each beat gives
// exactly one output beat with the hydrostatic a, b, c and wet a, b, c Niell
// coefficients in units of 2^-32, in input order.
// Both channels use valid and ready. The pipeline has eight register stages: the
// edge that accepts an input beat loads stage one, the beat then moves on through
// stages two to eight in order, and the result sits in stage eight with out_valid
// high until it is taken. One beat is accepted per cycle, sustained; every stage
// loads in every cycle while the output is not stalled.
// Each stage loads whenever it is empty or the stage behind it moves, so a stall at
// the output only holds stages that are full: bubbles close up and input is still
// taken until every stage holds a beat. Nothing is lost or repeated under a stall.
// Reset clears all valid bits; the pipeline is empty and in_ready is high right away.
// The seasonal cosine comes from a day-indexed constant ROM read in the first stage.
module niell_mapping_coefficients
	import nmc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] latitude,
	input  logic [8:0]         day_of_year,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [28:0]        hydro_a,
	output logic [28:0]        hydro_b,
	output logic [28:0]        hydro_c,
	output logic [28:0]        wet_a,
	output logic [28:0]        wet_b,
	output logic [28:0]        wet_c
);

	// valid_q[k] marks stage k+1 as holding a beat.
	logic [7:0]         valid_q;
	logic [8:0]         load;
	stage_en_t          en;

	logic signed [15:0] cs_s1;
	logic [2:0]         lo_s1;
	logic [2:0]         hi_s1;
	logic [19:0]        t_s1;

	logic [28:0]        hyd_out [NUM_COEF];
	logic [28:0]        wet_out [NUM_COEF];

	// A stage may load when it is empty or its contents move on in the same cycle.
	always_comb begin
		load[8] = out_ready;
		for (int k = 7; k >= 0; k--) begin
			load[k] = !valid_q[k] || load[k + 1];
		end
		en.s2 = load[1];
		en.s3 = load[2];
		en.s4 = load[3];
		en.s5 = load[4];
		en.s6 = load[5];
		en.s7 = load[6];
		en.s8 = load[7];
	end

	assign in_ready = load[0];
	assign out_valid = valid_q[7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < 8; k++) begin
				if (load[k]) begin
					valid_q[k] <= valid_q[k - 1];
				end
			end
		end
	end

	nmc_front u_front (
		.clk         (clk),
		.en          (load[0]),
		.latitude    (latitude),
		.day_of_year (day_of_year),
		.cs_s1       (cs_s1),
		.lo_s1       (lo_s1),
		.hi_s1       (hi_s1),
		.t_s1        (t_s1)
	);

	// Hydrostatic lanes take average and seasonal amplitude of both rows; wet lanes
	// have no seasonal term, so their amplitude is zero.
	for (genvar c = 0; c < NUM_COEF; c++) begin : g_coef
		nmc_lane u_hyd (
			.clk   (clk),
			.en    (en),
			.cs_s1 (cs_s1),
			.t_s1  (t_s1),
			.avg0  (29'(HYD_AVG[c][lo_s1])),
			.avg1  (29'(HYD_AVG[c][hi_s1])),
			.amp0  (24'(HYD_AMP[c][lo_s1])),
			.amp1  (24'(HYD_AMP[c][hi_s1])),
			.coef  (hyd_out[c])
		);

		nmc_lane u_wet (
			.clk   (clk),
			.en    (en),
			.cs_s1 (cs_s1),
			.t_s1  (t_s1),
			.avg0  (29'(WET_ROW[c][lo_s1])),
			.avg1  (29'(WET_ROW[c][hi_s1])),
			.amp0  (24'd0),
			.amp1  (24'd0),
			.coef  (wet_out[c])
		);
	end

	assign hydro_a = hyd_out[0];
	assign hydro_b = hyd_out[1];
	assign hydro_c = hyd_out[2];
	assign wet_a = wet_out[0];
	assign wet_b = wet_out[1];
	assign wet_c = wet_out[2];

endmodule
